/* hw/rtl/tmaf_pkg.sv */
// shared constants, codes and interface types of the trimmed-mean converter filter
package tmaf_pkg;

  // capture geometry
  localparam int SAMPLE_COUNT = 32;
  localparam int CHANNELS     = 4;
  localparam int SAMPLE_W     = 10;
  localparam int CHAN_IN_W    = 3;
  localparam int CHAN_OUT_W   = 2;
  localparam int ADDR_W       = $clog2(SAMPLE_COUNT);
  localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);

  // trim amount and kept range
  localparam int CUT      = SAMPLE_COUNT / 20;
  localparam int KEEP     = SAMPLE_COUNT - 2 * CUT;
  localparam int KEEP_LO  = CUT;
  localparam int KEEP_HI  = SAMPLE_COUNT - CUT - 1;
  localparam int SUM_W    = $clog2(KEEP * ((1 << SAMPLE_W) - 1) + 1);

  // reciprocal for floor(sum / KEEP), at most one low, fixed by one compare
  localparam int DIV_S    = SUM_W;
  localparam int RECIP    = (1 << DIV_S) / KEEP;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = SUM_W + RECIP_W;

  // item opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_STARTED  = 3'd0,
    ST_REJECTED = 3'd1,
    ST_STORED   = 3'd2,
    ST_DONE     = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  // top level sequencer
  typedef enum logic [1:0] {
    T_IDLE,
    T_SORT,
    T_DIV1,
    T_DIV2
  } top_state_t;

  // sorted store sequencer
  typedef enum logic [1:0] {
    SS_IDLE,
    SS_SHIFT,
    SS_PLACE,
    SS_SUM
  } sort_state_t;

  // insert request to the sorted store
  typedef struct packed {
    logic                insert;
    logic                last;
    logic [ADDR_W-1:0]   count;
    logic [SAMPLE_W-1:0] value;
  } sort_cmd_t;

  // completion from the sorted store
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } sort_stat_t;

endpackage

/* hw/rtl/trimmed_mean_adc_filter.sv */
// top level of the trimmed-mean converter filter: command decode, status and mean division
// Each accepted item (start high while busy is low) yields exactly one result, shown on the
// out_ ports for one cycle with out_valid high; the receiver cannot stall, so results must be
// taken when shown. Start items and samples outside a capture answer the next cycle and keep
// busy low, so they may come every cycle. A sample inside a capture is inserted in order into
// the sample memory, one entry moved per cycle over its single write port: busy stays high
// until the new sample is placed, after the stored samples larger than it (at most
// SAMPLE_COUNT - 1) have moved up. The sample that completes the batch adds a sweep over the
// SAMPLE_COUNT - 2*(SAMPLE_COUNT/20) kept entries through the read port, then the reciprocal
// division in T_DIV1 and T_DIV2, before the batch-done result appears.
module trimmed_mean_adc_filter
  import tmaf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [CHAN_IN_W-1:0]  in_channel,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [CHAN_OUT_W-1:0] out_result_channel,
  output logic [SAMPLE_W-1:0]   out_average
);

  top_state_t            state_r, state_nxt;
  logic                  capturing_r, capturing_nxt;
  logic [CHAN_OUT_W-1:0] cap_chan_r, cap_chan_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  last_r, last_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [PROD_W-1:0]     prod_r;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CHAN_OUT_W-1:0] out_chan_r, out_chan_nxt;
  logic [SAMPLE_W-1:0]   out_avg_r, out_avg_nxt;

  logic                  accept;
  logic                  chan_bad;
  logic [SUM_W-1:0]      quot_est;
  logic [SUM_W-1:0]      rem_est;
  logic [SUM_W-1:0]      quot;
  sort_cmd_t             sort_cmd;
  sort_stat_t            sort_stat;

  assign accept   = start && !busy;
  assign busy     = (state_r != T_IDLE);
  assign chan_bad = ({1'b0, in_channel} >= (CHAN_IN_W + 1)'(CHANNELS));

  // insert request for a sample inside a capture
  assign sort_cmd.insert = accept && (in_op == OP_SAMPLE) && capturing_r;
  assign sort_cmd.last   = (count_r + CNT_W'(1) == CNT_W'(SAMPLE_COUNT));
  assign sort_cmd.count  = count_r[ADDR_W-1:0];
  assign sort_cmd.value  = in_sample;

  tmaf_sort_store u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (sort_cmd),
    .stat (sort_stat)
  );

  // floor(sum / KEEP): reciprocal estimate, then one remainder correction
  assign quot_est = SUM_W'(prod_r >> DIV_S);
  assign rem_est  = sum_r - SUM_W'(quot_est * KEEP);
  assign quot     = (rem_est >= SUM_W'(KEEP)) ? quot_est + SUM_W'(1) : quot_est;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: if (sort_cmd.insert) state_nxt = T_SORT;
      T_SORT: begin
        if (sort_stat.done) begin
          state_nxt = last_r ? T_DIV1 : T_IDLE;
        end
      end
      T_DIV1:  state_nxt = T_DIV2;
      T_DIV2:  state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // capture state and results
  always_comb begin
    capturing_nxt  = capturing_r;
    cap_chan_nxt   = cap_chan_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_chan_nxt   = out_chan_r;
    out_avg_nxt    = '0;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          out_chan_nxt = cap_chan_r;
          if (in_op == OP_START) begin
            out_valid_nxt = 1'b1;
            if (chan_bad || capturing_r) begin
              out_status_nxt = ST_REJECTED;
            end else begin
              out_status_nxt = ST_STARTED;
              out_chan_nxt   = in_channel[CHAN_OUT_W-1:0];
              cap_chan_nxt   = in_channel[CHAN_OUT_W-1:0];
              capturing_nxt  = 1'b1;
              count_nxt      = '0;
            end
          end else if (!capturing_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_IGNORED;
          end else begin
            // sample stored: result follows once the insertion finishes
            count_nxt = count_r + CNT_W'(1);
            last_nxt  = sort_cmd.last;
          end
        end
      end
      T_SORT: begin
        if (sort_stat.done) begin
          if (last_r) begin
            sum_nxt = sort_stat.sum;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_STORED;
            out_chan_nxt   = cap_chan_r;
          end
        end
      end
      T_DIV2: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        out_chan_nxt   = cap_chan_r;
        out_avg_nxt    = quot[SAMPLE_W-1:0];
        capturing_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      capturing_r <= 1'b0;
      cap_chan_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capturing_r <= capturing_nxt;
      cap_chan_r  <= cap_chan_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    sum_r        <= sum_nxt;
    prod_r       <= PROD_W'(sum_r) * PROD_W'(RECIP);
    out_status_r <= out_status_nxt;
    out_chan_r   <= out_chan_nxt;
    out_avg_r    <= out_avg_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_channel = out_chan_r;
  assign out_average        = out_avg_r;

  // a result follows an accepted item, an insertion or the division
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept) || $past(state_r == T_DIV2) ||
                   $past(state_r == T_SORT && sort_stat.done)))
    else $error("result without a cause");

  // the store only completes while the sequencer waits for it
  a_done_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    sort_stat.done |-> (state_r == T_SORT))
    else $error("store completion outside sort wait");

  // sample count never passes the batch size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SAMPLE_COUNT))
    else $error("sample count overflow");

  // a mean is only reported with a batch-done status
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_average == '0))
    else $error("nonzero average without batch done");

endmodule

/* hw/rtl/tmaf_sort_store.sv */
// sample memory kept in ascending order by insertion, with trimmed-sum sweep
module tmaf_sort_store
  import tmaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sort_cmd_t  cmd,
  output sort_stat_t stat
);

  logic [SAMPLE_W-1:0] mem [SAMPLE_COUNT];
  logic [SAMPLE_W-1:0] rd_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [SAMPLE_W-1:0] wr_data;

  sort_state_t         state_r, state_nxt;
  logic [SAMPLE_W-1:0] key_r, key_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic                last_r, last_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic                finish;
  logic [SUM_W-1:0]    sum_now;

  // memory: one write port, one registered read port
  // a read of the entry being written returns the new data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  assign sum_now = acc_r + SUM_W'(rd_q);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SS_IDLE: begin
        if (cmd.insert) begin
          state_nxt = (cmd.count == '0) ? SS_PLACE : SS_SHIFT;
        end
      end
      SS_SHIFT: begin
        if (rd_q > key_r) begin
          if (pos_r == ADDR_W'(1)) begin
            state_nxt = SS_PLACE;
          end
        end else begin
          state_nxt = last_r ? SS_SUM : SS_IDLE;
        end
      end
      SS_PLACE: state_nxt = last_r ? SS_SUM : SS_IDLE;
      SS_SUM: begin
        if (pos_r == ADDR_W'(KEEP_HI)) begin
          state_nxt = SS_IDLE;
        end
      end
      default: state_nxt = SS_IDLE;
    endcase
  end

  // memory control and datapath
  always_comb begin
    key_nxt  = key_r;
    pos_nxt  = pos_r;
    last_nxt = last_r;
    acc_nxt  = acc_r;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = pos_r;
    wr_data  = key_r;
    finish   = 1'b0;
    case (state_r)
      SS_IDLE: begin
        if (cmd.insert) begin
          key_nxt  = cmd.value;
          pos_nxt  = cmd.count;
          last_nxt = cmd.last;
          rd_addr  = cmd.count - ADDR_W'(1);
        end
      end
      SS_SHIFT: begin
        wr_en = 1'b1;
        if (rd_q > key_r) begin
          // move the larger entry up one place and look one lower
          wr_data = rd_q;
          pos_nxt = pos_r - ADDR_W'(1);
          rd_addr = pos_r - ADDR_W'(2);
        end else begin
          finish = 1'b1;
        end
      end
      SS_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        finish  = 1'b1;
      end
      SS_SUM: begin
        // accumulate the kept range, one entry a cycle
        acc_nxt = sum_now;
        pos_nxt = pos_r + ADDR_W'(1);
        rd_addr = pos_r + ADDR_W'(1);
      end
      default: ;
    endcase
    // start the sweep over the kept range when the batch is complete
    if (finish && last_r) begin
      rd_addr = ADDR_W'(KEEP_LO);
      pos_nxt = ADDR_W'(KEEP_LO);
      acc_nxt = '0;
    end
  end

  // completion
  always_comb begin
    stat.done = 1'b0;
    stat.sum  = sum_now;
    case (state_r)
      SS_SHIFT, SS_PLACE: stat.done = finish && !last_r;
      SS_SUM:             stat.done = (pos_r == ADDR_W'(KEEP_HI));
      default:            stat.done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    pos_r  <= pos_nxt;
    last_r <= last_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

/* tb/tmaf_checker.sv */
// result checker of the trimmed-mean converter filter: tracks accepted items and compares results
`timescale 1ns / 1ps

module tmaf_checker
  import tmaf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_op,
  input  logic [CHAN_IN_W-1:0]  in_channel,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  out_valid,
  input  logic [2:0]            out_status,
  input  logic [CHAN_OUT_W-1:0] out_result_channel,
  input  logic [SAMPLE_W-1:0]   out_average,
  output int                    fail_count,
  output int                    outstanding
);

  // readings dropped at each end of the sorted batch
  localparam int DROP_N = SAMPLE_COUNT / 20;
  localparam int KEPT_N = SAMPLE_COUNT - 2 * DROP_N;

  typedef struct {
    status_t                status;
    logic [CHAN_OUT_W-1:0]  chan;
    logic [SAMPLE_W-1:0]    avg;
  } filter_result_t;

  // shadow copy of the filter state
  logic [SAMPLE_W-1:0]   cap_samples [SAMPLE_COUNT];
  int unsigned           cap_count;
  logic                  capturing;
  logic [CHAN_OUT_W-1:0] cap_chan;
  logic [SAMPLE_W-1:0]   chan_cache [CHANNELS];

  filter_result_t result_q [$];
  filter_result_t want;
  int             err_n;

  function automatic void clear_filter();
    for (int i = 0; i < SAMPLE_COUNT; i++) cap_samples[i] = '0;
    for (int i = 0; i < CHANNELS; i++) chan_cache[i] = '0;
    cap_count = 0;
    capturing = 1'b0;
    cap_chan  = '0;
  endfunction

  // sort a copy of the batch, drop both tails, floor mean of the rest
  function automatic logic [SAMPLE_W-1:0] trimmed_average();
    logic [SAMPLE_W-1:0] v [SAMPLE_COUNT];
    logic [SAMPLE_W-1:0] key;
    int                  j;
    int unsigned         sum;
    v = cap_samples;
    for (int i = 1; i < SAMPLE_COUNT; i++) begin
      key = v[i];
      j = i;
      while (j > 0 && v[j-1] > key) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = key;
    end
    sum = 0;
    for (int i = DROP_N; i < SAMPLE_COUNT - DROP_N; i++) sum += v[i];
    return SAMPLE_W'(sum / KEPT_N);
  endfunction

  // advance the shadow state by one item and return the result it causes
  function automatic filter_result_t next_result(logic op, logic [CHAN_IN_W-1:0] ch,
                                                 logic [SAMPLE_W-1:0] smp);
    filter_result_t r;
    r.avg  = '0;
    r.chan = cap_chan;
    if (op == OP_START) begin
      if (ch >= CHANNELS || capturing) begin
        r.status = ST_REJECTED;
      end else begin
        for (int i = 0; i < SAMPLE_COUNT; i++) cap_samples[i] = '0;
        cap_count = 0;
        cap_chan  = ch[CHAN_OUT_W-1:0];
        capturing = 1'b1;
        r.status  = ST_STARTED;
        r.chan    = ch[CHAN_OUT_W-1:0];
      end
    end else if (!capturing) begin
      r.status = ST_IGNORED;
    end else begin
      cap_samples[cap_count] = smp;
      cap_count++;
      if (cap_count >= SAMPLE_COUNT) begin
        r.avg = trimmed_average();
        chan_cache[cap_chan] = r.avg;
        capturing = 1'b0;
        r.status  = ST_DONE;
      end else begin
        r.status = ST_STORED;
      end
    end
    return r;
  endfunction

  // predict on each accepted item, compare each shown result with the oldest one
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_filter();
      result_q.delete();
      err_n = 0;
    end else begin
      if (start && !busy) result_q.push_back(next_result(in_op, in_channel, in_sample));
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $error("result with no item pending: status %0d channel %0d average %0d",
                 out_status, out_result_channel, out_average);
          err_n++;
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_status);
            err_n++;
          end
          if (out_result_channel !== want.chan) begin
            $error("result_channel: expected %0d actual %0d", want.chan, out_result_channel);
            err_n++;
          end
          if (out_average !== want.avg) begin
            $error("average: expected %0d actual %0d", want.avg, out_average);
            err_n++;
          end
        end
      end
    end
    fail_count  <= err_n;
    outstanding <= result_q.size();
  end

endmodule

/* tb/tb_top.sv */
// testbench top of the trimmed-mean converter filter: clock, reset, item stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import tmaf_pkg::*;

  localparam int ITEM_GOAL  = 1500;
  localparam int CALM_AFTER = 1300;
  localparam int TAIL_CYC   = 2 * SAMPLE_COUNT + 16;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  start      = 1'b0;
  logic                  in_op      = OP_START;
  logic [CHAN_IN_W-1:0]  in_channel = '0;
  logic [SAMPLE_W-1:0]   in_sample  = '0;
  logic                  busy;
  logic                  out_valid;
  logic [2:0]            out_status;
  logic [CHAN_OUT_W-1:0] out_result_channel;
  logic [SAMPLE_W-1:0]   out_average;
  int                    fail_count;
  int                    outstanding;

  int items_sent = 0;
  bit gaps_on    = 1'b1;

  always #2 clk = ~clk;

  trimmed_mean_adc_filter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_channel         (in_channel),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_channel (out_result_channel),
    .out_average        (out_average)
  );

  tmaf_checker i_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_channel         (in_channel),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_channel (out_result_channel),
    .out_average        (out_average),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  // present one item and hold it until an edge with busy low takes it
  task automatic send_item(logic op, logic [CHAN_IN_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
    start      <= 1'b1;
    in_op      <= op;
    in_channel <= ch;
    in_sample  <= smp;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // random sender gap, with start dropped while it lasts
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // hold off until every pending result has come out
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // reading for sample k of a batch in a given shape
  function automatic logic [SAMPLE_W-1:0] shaped_sample(int shape, int k,
                                                        logic [SAMPLE_W-1:0] base);
    case (shape)
      0: return SAMPLE_W'($urandom_range(0, 1023));
      1: return base;
      2: return SAMPLE_W'(base + k * 3);
      3: return SAMPLE_W'(base - k * 5);
      4: return $urandom_range(0, 1) ? '1 : '0;
      default: begin
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
        return SAMPLE_W'(512 + $urandom_range(0, 40) - 20);
      end
    endcase
  endfunction

  // one capture with random content, some stray items mixed in
  task automatic run_capture();
    int                  shape;
    logic [SAMPLE_W-1:0] base;
    shape = $urandom_range(0, 5);
    base  = SAMPLE_W'($urandom_range(0, 1023));
    send_item(OP_START, CHAN_IN_W'($urandom_range(0, 3)), SAMPLE_W'($urandom));
    maybe_gap();
    for (int k = 0; k < SAMPLE_COUNT; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        // start while a capture runs is turned away
        send_item(OP_START, CHAN_IN_W'($urandom_range(0, 7)), SAMPLE_W'($urandom));
        maybe_gap();
      end
      send_item(OP_SAMPLE, CHAN_IN_W'($urandom), shaped_sample(shape, k, base));
      maybe_gap();
    end
  endtask

  // stray items between captures
  task automatic run_noise();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 1) == 0)
        send_item(OP_SAMPLE, CHAN_IN_W'($urandom), SAMPLE_W'($urandom));
      else
        send_item(OP_START, CHAN_IN_W'($urandom_range(4, 7)), SAMPLE_W'($urandom));
      maybe_gap();
    end
  endtask

  // main sequence
  initial begin
    int captures;
    captures = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray sample, out-of-range starts, start while a capture runs, extreme readings
    send_item(OP_SAMPLE, 3'd5, 10'd1023);
    send_item(OP_START, 3'd4, 10'd0);
    send_item(OP_START, 3'd7, 10'd1023);
    send_item(OP_START, 3'd3, 10'd0);
    send_item(OP_START, 3'd0, 10'd0);
    for (int k = 0; k < SAMPLE_COUNT; k++) begin
      case (k)
        0:       send_item(OP_SAMPLE, 3'd7, 10'd0);
        1:       send_item(OP_SAMPLE, 3'd0, 10'd1023);
        2:       send_item(OP_SAMPLE, 3'd2, 10'd1023);
        3:       send_item(OP_SAMPLE, 3'd1, 10'd0);
        default: send_item(OP_SAMPLE, 3'd0, SAMPLE_W'(k * 37));
      endcase
    end
    send_item(OP_SAMPLE, 3'd6, 10'd1);
    wait_drained();

    // random captures
    while (items_sent < ITEM_GOAL) begin
      if (items_sent > CALM_AFTER) gaps_on = 1'b0;
      run_noise();
      run_capture();
      captures++;
      if (captures % 10 == 0) wait_drained();
    end

    // let the last results out, then a tail for anything stray
    wait_drained();
    repeat (TAIL_CYC) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS trimmed_mean_adc_filter");
    end else begin
      $display("FAIL trimmed_mean_adc_filter");
    end
    $finish;
  end

  // run time limit
  initial begin
    #3_000_000;
    $display("FAIL trimmed_mean_adc_filter");
    $finish;
  end

endmodule

/* trimmed_mean_adc_filter.f */
hw/rtl/tmaf_pkg.sv
hw/rtl/tmaf_sort_store.sv
hw/rtl/trimmed_mean_adc_filter.sv
tb/tmaf_checker.sv
tb/tb_top.sv
